### src/scp_pkg.sv
// Shared widths, constants, coefficient tables and chain type of the sine/cosine block.
package scp_pkg;

    localparam int ANGLE_W   = 32;
    localparam int OUT_W     = 32;
    localparam int INV_PI_W  = 31;
    localparam int PI_W      = 34;
    localparam int X_W       = 36;
    localparam int Z_W       = 38;
    localparam int XZ_W      = 40;
    localparam int U_W       = 62;
    localparam int S_W       = 40;
    localparam int N_TERMS   = 6;
    localparam int Q_SHIFT   = 32;
    localparam int P_SHIFT   = 60;

    localparam logic [INV_PI_W-1:0] INV_PI_Q32 = 31'd1367130551;
    localparam logic [PI_W-1:0]     PI_Q32     = 34'd13493037705;
    localparam logic signed [S_W-1:0] ONE_Q32  = 40'sd4294967296;
    localparam logic [OUT_W-1:0]    ONE_Q30    = 32'd1073741824;

    localparam logic signed [U_W-1:0] SIN_COEF [N_TERMS] = '{
        62'sd155973539,
        -62'sd28480785949,
        62'sd3174330247014,
        -62'sd228744019144900,
        62'sd9607661411657000,
        -62'sd192153576414997799
    };

    localparam logic signed [U_W-1:0] COS_COEF [N_TERMS] = '{
        62'sd1993472301,
        -62'sd312366626422,
        62'sd28559759910000,
        -62'sd1601166548000000,
        62'sd48038225777285291,
        -62'sd576460648540488073
    };

    typedef struct packed {
        logic                    valid;
        logic signed [U_W-1:0]   u_sin;
        logic signed [U_W-1:0]   u_cos;
        logic signed [Z_W-1:0]   z;
        logic signed [X_W-1:0]   x;
        logic signed [XZ_W-1:0]  xz;
    } t_chain;

endpackage

### src/scp_mul_round.sv
// Four-stage signed multiplier with symmetric rounding shift, addend and side-band delay.
module scp_mul_round #(
    parameter int A_W    = 36,
    parameter int B_W    = 36,
    parameter int R_W    = 38,
    parameter int SHIFT  = 32,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [B_W-1:0] i_b,
    input  logic signed [R_W-1:0] i_addend,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic signed [R_W-1:0] o_res,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int LO_W = (A_W + 1) / 2;
    localparam int HI_W = A_W - LO_W;
    localparam int PL_W = LO_W + B_W;
    localparam int PH_W = HI_W + B_W;
    localparam int P_W  = A_W + B_W;
    localparam logic [A_W-1:0] A_ONE = A_W'(1);
    localparam logic [B_W-1:0] B_ONE = B_W'(1);
    localparam logic [P_W-1:0] HALF  = P_W'(1) << (SHIFT - 1);

    logic [A_W-1:0]    a_bits;
    logic [B_W-1:0]    b_bits;
    logic [A_W-1:0]    n_am;
    logic [B_W-1:0]    n_bm;
    logic [PL_W-1:0]   n_pl;
    logic [PH_W-1:0]   n_ph;
    logic [P_W-1:0]    n_full;
    logic [R_W-1:0]    n_rm;
    logic [R_W-1:0]    n_res;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic [A_W-1:0]    r1_am;
    logic [B_W-1:0]    r1_bm;
    logic              r1_neg, r2_neg, r3_neg;
    logic [R_W-1:0]    r1_add, r2_add, r3_add;
    logic [SIDE_W-1:0] r1_side, r2_side, r3_side, r4_side;
    logic [PL_W-1:0]   r2_pl;
    logic [PH_W-1:0]   r2_ph;
    logic [R_W-1:0]    r3_rm;
    logic [R_W-1:0]    r4_res;

    assign a_bits = i_a;
    assign b_bits = i_b;

    always_comb begin
        n_am   = a_bits[A_W-1] ? (~a_bits + A_ONE) : a_bits;
        n_bm   = b_bits[B_W-1] ? (~b_bits + B_ONE) : b_bits;
        n_pl   = PL_W'(r1_am[LO_W-1:0]) * PL_W'(r1_bm);
        n_ph   = PH_W'(r1_am[A_W-1:LO_W]) * PH_W'(r1_bm);
        n_full = (P_W'(r2_ph) << LO_W) + P_W'(r2_pl) + HALF;
        n_rm   = n_full[SHIFT +: R_W];
        n_res  = r3_neg ? (r3_add - r3_rm) : (r3_add + r3_rm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_am   <= n_am;
        r1_bm   <= n_bm;
        r1_neg  <= a_bits[A_W-1] ^ b_bits[B_W-1];
        r1_add  <= i_addend;
        r1_side <= i_side;
        r2_pl   <= n_pl;
        r2_ph   <= n_ph;
        r2_neg  <= r1_neg;
        r2_add  <= r1_add;
        r2_side <= r1_side;
        r3_rm   <= n_rm;
        r3_neg  <= r2_neg;
        r3_add  <= r2_add;
        r3_side <= r2_side;
        r4_res  <= n_res;
        r4_side <= r3_side;
    end

    assign o_valid = r_v4;
    assign o_res   = r4_res;
    assign o_side  = r4_side;

endmodule

### src/scp_reduce.sv
// Five-stage range reduction of the angle by whole half-turns into a Q32 remainder.
module scp_reduce #(
    parameter int FRAC_W = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [scp_pkg::ANGLE_W-1:0]   i_angle,
    output logic                                 o_valid,
    output logic signed [scp_pkg::X_W-1:0]       o_x
);

    localparam int ANG_W  = scp_pkg::ANGLE_W;
    localparam int XW     = scp_pkg::X_W;
    localparam int PROD_W = ANG_W + scp_pkg::INV_PI_W;
    localparam int CNT_W  = PROD_W - FRAC_W - scp_pkg::Q_SHIFT;
    localparam int MS_W   = ANG_W + scp_pkg::Q_SHIFT - FRAC_W;
    localparam int CP_W   = CNT_W + scp_pkg::PI_W;
    localparam logic [ANG_W-1:0] ANG_ONE = ANG_W'(1);
    localparam logic [XW-1:0]    PI_X    = XW'(scp_pkg::PI_Q32);

    logic [ANG_W-1:0]  a_bits;
    logic [PROD_W-1:0] prod;
    logic [MS_W-1:0]   mshift;
    logic [CP_W-1:0]   cp;
    logic [XW-1:0]     minuend;
    logic [XW-1:0]     subtrahend;

    logic              r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [ANG_W-1:0]  r1_mag, r2_mag;
    logic              r1_neg, r2_neg, r3_neg, r4_neg;
    logic [CNT_W-1:0]  r2_cnt;
    logic [XW-1:0]     r3_m, r3_cp;
    logic              r3_odd, r4_odd;
    logic [XW-1:0]     r4_xp;
    logic [XW-1:0]     r5_x;

    assign a_bits = i_angle;

    always_comb begin
        prod   = PROD_W'(r1_mag) * PROD_W'(scp_pkg::INV_PI_Q32);
        mshift = {r2_mag, {(MS_W - ANG_W){1'b0}}};
        cp     = CP_W'(r2_cnt) * CP_W'(scp_pkg::PI_Q32);
        case ({r4_odd, r4_neg})
            2'b00: begin
                minuend    = r4_xp;
                subtrahend = '0;
            end
            2'b01: begin
                minuend    = '0;
                subtrahend = r4_xp;
            end
            2'b11: begin
                minuend    = PI_X;
                subtrahend = r4_xp;
            end
            default: begin
                if (r4_xp != '0) begin
                    minuend    = r4_xp;
                    subtrahend = PI_X;
                end else begin
                    minuend    = PI_X;
                    subtrahend = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mag <= a_bits[ANG_W-1] ? (~a_bits + ANG_ONE) : a_bits;
        r1_neg <= a_bits[ANG_W-1];
        r2_cnt <= prod[PROD_W-1 -: CNT_W];
        r2_mag <= r1_mag;
        r2_neg <= r1_neg;
        r3_m   <= mshift[XW-1:0];
        r3_cp  <= cp[XW-1:0];
        r3_neg <= r2_neg;
        r3_odd <= r2_cnt[0];
        r4_xp  <= r3_m - r3_cp;
        r4_neg <= r3_neg;
        r4_odd <= r3_odd;
        r5_x   <= minuend - subtrahend;
    end

    assign o_valid = r_v5;
    assign o_x     = r5_x;

endmodule

### src/scp_horner_cell.sv
// One Horner step for both polynomials, passing the shared operands to the next cell.
module scp_horner_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scp_pkg::t_chain                   i_chain,
    input  logic signed [scp_pkg::U_W-1:0]    i_coef_sin,
    input  logic signed [scp_pkg::U_W-1:0]    i_coef_cos,
    output scp_pkg::t_chain                   o_chain
);

    localparam int UW  = scp_pkg::U_W;
    localparam int XW  = scp_pkg::X_W;
    localparam int ZW  = scp_pkg::Z_W;
    localparam int XZW = scp_pkg::XZ_W;

    logic                  v_sin;
    logic                  v_cos;
    logic signed [UW-1:0]  u_sin;
    logic signed [UW-1:0]  u_cos;
    logic [XW+XZW-1:0]     side_sin;
    logic [ZW-1:0]         side_cos;

    scp_mul_round #(
        .A_W    (UW),
        .B_W    (ZW),
        .R_W    (UW),
        .SHIFT  (scp_pkg::Q_SHIFT),
        .SIDE_W (XW + XZW)
    ) u_sin_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_chain.valid),
        .i_a      (i_chain.u_sin),
        .i_b      (i_chain.z),
        .i_addend (i_coef_sin),
        .i_side   ({i_chain.x, i_chain.xz}),
        .o_valid  (v_sin),
        .o_res    (u_sin),
        .o_side   (side_sin)
    );

    scp_mul_round #(
        .A_W    (UW),
        .B_W    (ZW),
        .R_W    (UW),
        .SHIFT  (scp_pkg::Q_SHIFT),
        .SIDE_W (ZW)
    ) u_cos_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_chain.valid),
        .i_a      (i_chain.u_cos),
        .i_b      (i_chain.z),
        .i_addend (i_coef_cos),
        .i_side   (i_chain.z),
        .o_valid  (v_cos),
        .o_res    (u_cos),
        .o_side   (side_cos)
    );

    always_comb begin
        o_chain.valid = v_sin & v_cos;
        o_chain.u_sin = u_sin;
        o_chain.u_cos = u_cos;
        o_chain.z     = side_cos;
        o_chain.x     = side_sin[XW+XZW-1:XZW];
        o_chain.xz    = side_sin[XZW-1:0];
    end

endmodule

### src/scp_sat.sv
// Two-stage conversion of a Q32 value to Q30 with symmetric rounding and saturation to one.
module scp_sat (
    input  logic                                i_clk,
    input  logic signed [scp_pkg::S_W-1:0]      i_value,
    output logic signed [scp_pkg::OUT_W-1:0]    o_value
);

    localparam int SW = scp_pkg::S_W;
    localparam int OW = scp_pkg::OUT_W;
    localparam int MW = SW - 2;

    logic [SW-1:0] v_bits;
    logic [SW-1:0] n_biased;
    logic          over;
    logic [OW-1:0] mag_c;
    logic [OW-1:0] n_out;

    logic [MW-1:0] r_mag;
    logic          r_neg;
    logic [OW-1:0] r_out;

    assign v_bits = i_value;

    always_comb begin
        n_biased = v_bits[SW-1] ? (~v_bits + SW'(3)) : (v_bits + SW'(2));
        over     = r_mag > MW'(scp_pkg::ONE_Q30);
        mag_c    = over ? scp_pkg::ONE_Q30 : r_mag[OW-1:0];
        n_out    = r_neg ? (OW'(0) - mag_c) : mag_c;
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_biased[SW-1:2];
        r_neg <= v_bits[SW-1];
        r_out <= n_out;
    end

    assign o_value = r_out;

endmodule

### src/sine_cosine_polynomial.sv
// Top level of the pipelined sine and cosine block.
// One signed angle in radians (ANGLE_FRAC_BITS fraction bits) is taken in every clock cycle
// while start is high; busy never rises. Each transfer yields its sine and cosine in Q2.30,
// saturated to plus or minus one, on o_sine_value and o_cosine_value for exactly one cycle
// with o_done high, in input order. The receiver must capture each result in that cycle.
// The pipeline consists of a five-stage range reduction, eight four-stage multiply cells in a
// row (square, cube, five Horner cells and the final products) and a two-stage rounding and
// saturation step.
module sine_cosine_polynomial #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [scp_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_done,
    output logic signed [scp_pkg::OUT_W-1:0]    o_sine_value,
    output logic signed [scp_pkg::OUT_W-1:0]    o_cosine_value
);

    localparam int XW  = scp_pkg::X_W;
    localparam int ZW  = scp_pkg::Z_W;
    localparam int XZW = scp_pkg::XZ_W;
    localparam int UW  = scp_pkg::U_W;
    localparam int SW  = scp_pkg::S_W;
    localparam int NT  = scp_pkg::N_TERMS;

    logic                   red_valid;
    logic signed [XW-1:0]   red_x;
    logic                   z_valid;
    logic signed [ZW-1:0]   z_val;
    logic [XW-1:0]          z_x;
    logic                   xz_valid;
    logic signed [XZW-1:0]  xz_val;
    logic [ZW+XW-1:0]       xz_side;
    scp_pkg::t_chain        w_chain [NT];
    logic signed [SW-1:0]   sin_addend;
    logic                   fin_valid_sin;
    logic                   fin_valid_cos;
    logic signed [SW-1:0]   sin_q32;
    logic signed [SW-1:0]   cos_q32;

    logic                   r_sat_valid;
    logic                   r_done;

    assign busy = 1'b0;

    scp_reduce #(
        .FRAC_W (ANGLE_FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_angle (i_angle),
        .o_valid (red_valid),
        .o_x     (red_x)
    );

    scp_mul_round #(
        .A_W    (XW),
        .B_W    (XW),
        .R_W    (ZW),
        .SHIFT  (scp_pkg::Q_SHIFT),
        .SIDE_W (XW)
    ) u_square (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (red_valid),
        .i_a      (red_x),
        .i_b      (red_x),
        .i_addend ('0),
        .i_side   (red_x),
        .o_valid  (z_valid),
        .o_res    (z_val),
        .o_side   (z_x)
    );

    scp_mul_round #(
        .A_W    (ZW),
        .B_W    (XW),
        .R_W    (XZW),
        .SHIFT  (scp_pkg::Q_SHIFT),
        .SIDE_W (ZW + XW)
    ) u_cube (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (z_valid),
        .i_a      (z_val),
        .i_b      (z_x),
        .i_addend ('0),
        .i_side   ({z_val, z_x}),
        .o_valid  (xz_valid),
        .o_res    (xz_val),
        .o_side   (xz_side)
    );

    always_comb begin
        w_chain[0].valid = xz_valid;
        w_chain[0].u_sin = scp_pkg::SIN_COEF[0];
        w_chain[0].u_cos = scp_pkg::COS_COEF[0];
        w_chain[0].z     = xz_side[ZW+XW-1:XW];
        w_chain[0].x     = xz_side[XW-1:0];
        w_chain[0].xz    = xz_val;
    end

    for (genvar k = 1; k < NT; k++) begin : g_cell
        scp_horner_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_chain    (w_chain[k-1]),
            .i_coef_sin (scp_pkg::SIN_COEF[k]),
            .i_coef_cos (scp_pkg::COS_COEF[k]),
            .o_chain    (w_chain[k])
        );
    end

    assign sin_addend = {{(SW - XW){w_chain[NT-1].x[XW-1]}}, w_chain[NT-1].x};

    scp_mul_round #(
        .A_W    (UW),
        .B_W    (XZW),
        .R_W    (SW),
        .SHIFT  (scp_pkg::P_SHIFT),
        .SIDE_W (1)
    ) u_sin_final (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_chain[NT-1].valid),
        .i_a      (w_chain[NT-1].u_sin),
        .i_b      (w_chain[NT-1].xz),
        .i_addend (sin_addend),
        .i_side   (1'b0),
        .o_valid  (fin_valid_sin),
        .o_res    (sin_q32),
        .o_side   ()
    );

    scp_mul_round #(
        .A_W    (UW),
        .B_W    (ZW),
        .R_W    (SW),
        .SHIFT  (scp_pkg::P_SHIFT),
        .SIDE_W (1)
    ) u_cos_final (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_chain[NT-1].valid),
        .i_a      (w_chain[NT-1].u_cos),
        .i_b      (w_chain[NT-1].z),
        .i_addend (scp_pkg::ONE_Q32),
        .i_side   (1'b0),
        .o_valid  (fin_valid_cos),
        .o_res    (cos_q32),
        .o_side   ()
    );

    scp_sat u_sin_sat (
        .i_clk   (i_clk),
        .i_value (sin_q32),
        .o_value (o_sine_value)
    );

    scp_sat u_cos_sat (
        .i_clk   (i_clk),
        .i_value (cos_q32),
        .o_value (o_cosine_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_sat_valid <= fin_valid_sin & fin_valid_cos;
            r_done      <= r_sat_valid;
        end
    end

    assign o_done = r_done;

endmodule

### src/scp_checker.sv
// Port-level checker of the sine and cosine block and its bind to the top level.
module scp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic signed [scp_pkg::ANGLE_W-1:0]  i_angle,
    input logic                                o_done,
    input logic signed [scp_pkg::OUT_W-1:0]    o_sine_value,
    input logic signed [scp_pkg::OUT_W-1:0]    o_cosine_value
);

    localparam int LATENCY = 39;
    localparam logic signed [scp_pkg::OUT_W-1:0] POS_ONE = scp_pkg::ONE_Q30;
    localparam logic signed [scp_pkg::OUT_W-1:0] NEG_ONE = -scp_pkg::ONE_Q30;

    a_sine_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_sine_value <= POS_ONE && o_sine_value >= NEG_ONE))
        else $error("Sine result is outside plus or minus one.");

    a_cosine_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_cosine_value <= POS_ONE && o_cosine_value >= NEG_ONE))
        else $error("Cosine result is outside plus or minus one.");

    a_done_from_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("Result strobe without a matching start transfer.");

    a_zero_angle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_angle == '0, LATENCY))
            |-> (o_sine_value == '0 && o_cosine_value == POS_ONE))
        else $error("Zero angle did not give sine zero and cosine one.");

endmodule

bind sine_cosine_polynomial scp_checker u_scp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_angle        (i_angle),
    .o_done         (o_done),
    .o_sine_value   (o_sine_value),
    .o_cosine_value (o_cosine_value)
);
